FILE: sv/aspsf_pkg.sv
package aspsf_pkg;

  localparam int MAX_ASNS     = 1024;
  localparam int CNT_W        = $clog2(MAX_ASNS + 1);
  localparam int IDX_W        = 10;
  localparam int TOT_W        = 11;
  localparam int OFF_W        = 13;
  localparam int MIN_PATH_LEN = 6;
  localparam int MAX_PATH_LEN = 4096;
  localparam int HDR_BYTES    = 2;
  localparam int ASN_BYTES    = 4;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0]  path_byte;
    logic [15:0] path_length;
    logic        first_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0]      as_number;
    logic [IDX_W-1:0] as_index;
    logic             status;
    logic             path_done;
    logic [TOT_W-1:0] as_total;
  } out_word_t;

  typedef enum logic {
    EV_ASN = 1'b0,
    EV_BAD = 1'b1
  } ev_kind_t;

  typedef struct packed {
    logic        restart;
    ev_kind_t    kind;
    logic        done;
    logic [31:0] asn;
  } event_t;

endpackage

FILE: sv/aspsf_front.sv
module aspsf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  aspsf_pkg::in_word_t in_word,
  output logic                push,
  output aspsf_pkg::event_t   push_event
);

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_COUNT = 2'd1,
    PH_ASN   = 2'd2
  } phase_t;

  logic [aspsf_pkg::OFF_W-1:0] off_r, off_nxt, tot_r, tot_nxt;
  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  left_r, left_nxt;
  logic [1:0]                  bpos_r, bpos_nxt;
  logic [23:0]                 acc_r, acc_nxt;
  logic                        skip_r, skip_nxt;
  logic                        pend_r, pend_nxt;

  logic [aspsf_pkg::OFF_W-1:0] e_off;
  phase_t                      e_phase;
  logic [7:0]                  e_left, left_dec;
  logic [1:0]                  e_bpos;
  logic [23:0]                 e_acc;
  logic                        bad_len, ev_push, ev_bad, ev_done;
  logic [31:0]                 ev_asn;
  logic [aspsf_pkg::OFF_W:0]   seg_end;
  logic [15:0]                 len;
  logic [7:0]                  b;

  assign len = in_word.path_length;
  assign b   = in_word.path_byte;

  always_comb begin
    e_off    = in_word.first_byte ? '0 : off_r;
    e_phase  = in_word.first_byte ? PH_TYPE : phase_r;
    e_left   = in_word.first_byte ? '0 : left_r;
    e_bpos   = in_word.first_byte ? '0 : bpos_r;
    e_acc    = in_word.first_byte ? '0 : acc_r;
    bad_len  = (len < 16'(aspsf_pkg::MIN_PATH_LEN)) || (len > 16'(aspsf_pkg::MAX_PATH_LEN))
               || len[0];
    seg_end  = {1'b0, e_off} + (aspsf_pkg::OFF_W+1)'(aspsf_pkg::HDR_BYTES - 1)
               + {{(aspsf_pkg::OFF_W-9){1'b0}}, b, 2'b00};
    left_dec = e_left - 8'd1;

    off_nxt   = off_r;
    tot_nxt   = tot_r;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    bpos_nxt  = bpos_r;
    acc_nxt   = acc_r;
    skip_nxt  = skip_r;
    ev_push   = 1'b0;
    ev_bad    = 1'b0;
    ev_done   = 1'b0;
    ev_asn    = {e_acc, b};

    if (accept && (in_word.first_byte || !skip_r)) begin
      off_nxt   = e_off + 1'b1;
      phase_nxt = e_phase;
      left_nxt  = e_left;
      bpos_nxt  = e_bpos;
      acc_nxt   = e_acc;
      skip_nxt  = 1'b0;
      if (in_word.first_byte) begin
        tot_nxt = len[aspsf_pkg::OFF_W-1:0];
      end
      if (in_word.first_byte && bad_len) begin
        skip_nxt = 1'b1;
        ev_push  = 1'b1;
        ev_bad   = 1'b1;
        ev_done  = 1'b1;
        off_nxt  = '0;
      end else begin
        case (e_phase)
          PH_COUNT: begin
            if ((b == 8'd0) || (seg_end > {1'b0, tot_nxt})) begin
              skip_nxt = 1'b1;
              ev_push  = 1'b1;
              ev_bad   = 1'b1;
              ev_done  = 1'b1;
            end else begin
              left_nxt  = b;
              bpos_nxt  = '0;
              acc_nxt   = '0;
              phase_nxt = PH_ASN;
            end
          end
          PH_ASN: begin
            if (e_bpos != 2'd3) begin
              acc_nxt  = {e_acc[15:0], b};
              bpos_nxt = e_bpos + 2'd1;
            end else begin
              acc_nxt  = '0;
              bpos_nxt = '0;
              left_nxt = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = PH_TYPE;
              end
              ev_push = 1'b1;
              ev_done = (off_nxt == tot_nxt);
              if (ev_done) begin
                skip_nxt = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = PH_COUNT;
          end
        endcase
      end
    end

    if (ev_push) begin
      pend_nxt = 1'b0;
    end else if (accept && in_word.first_byte) begin
      pend_nxt = 1'b1;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      tot_r   <= '0;
      phase_r <= PH_TYPE;
      left_r  <= '0;
      bpos_r  <= '0;
      acc_r   <= '0;
      skip_r  <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      off_r   <= off_nxt;
      tot_r   <= tot_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      bpos_r  <= bpos_nxt;
      acc_r   <= acc_nxt;
      skip_r  <= skip_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign push               = ev_push;
  assign push_event.restart = in_word.first_byte || pend_r;
  assign push_event.kind    = ev_bad ? aspsf_pkg::EV_BAD : aspsf_pkg::EV_ASN;
  assign push_event.done    = ev_done;
  assign push_event.asn     = ev_bad ? 32'd0 : ev_asn;

endmodule

FILE: sv/aspsf_queue.sv
module aspsf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aspsf_pkg::event_t push_event,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output aspsf_pkg::event_t head
);

  aspsf_pkg::event_t         mem [aspsf_pkg::QDEPTH];
  logic [aspsf_pkg::QAW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [aspsf_pkg::QAW:0]   cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != (aspsf_pkg::QAW+1)'(aspsf_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (aspsf_pkg::QAW+1)'(push) - (aspsf_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_event;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("event pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("event popped from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (aspsf_pkg::QAW+1)'(aspsf_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/aspsf_back.sv
module aspsf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ev_valid,
  input  aspsf_pkg::event_t    ev,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aspsf_pkg::out_word_t out_word
);

  logic [aspsf_pkg::CNT_W-1:0] stored_r, stored_nxt, cnt;
  logic                        out_valid_r, out_valid_nxt;
  aspsf_pkg::out_word_t        out_r, out_nxt;
  logic                        kept;

  assign pop  = ev_valid && (!out_valid_r || out_ready);
  assign cnt  = ev.restart ? '0 : stored_r;
  assign kept = cnt < aspsf_pkg::CNT_W'(aspsf_pkg::MAX_ASNS);

  always_comb begin
    stored_nxt    = stored_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      stored_nxt         = cnt;
      out_nxt.as_number  = 32'd0;
      out_nxt.as_index   = '0;
      out_nxt.status     = 1'b0;
      out_nxt.path_done  = ev.done;
      out_nxt.as_total   = aspsf_pkg::TOT_W'(cnt);
      if (ev.kind == aspsf_pkg::EV_BAD) begin
        out_nxt.status = 1'b1;
        out_valid_nxt  = 1'b1;
      end else if (kept) begin
        stored_nxt        = cnt + 1'b1;
        out_nxt.as_number = ev.asn;
        out_nxt.as_index  = aspsf_pkg::IDX_W'(cnt);
        out_nxt.as_total  = aspsf_pkg::TOT_W'(stored_nxt);
        out_valid_nxt     = 1'b1;
      end else if (ev.done) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_bad_ends_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |-> out_r.path_done)
    else $error("malformed word without end of path");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= aspsf_pkg::CNT_W'(aspsf_pkg::MAX_ASNS))
    else $error("stored count beyond capacity");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("event consumed while the output word is stalled");

endmodule

FILE: sv/as_path_segment_flattener_top.sv
// AS_PATH flattener. Attribute bytes enter one word per cycle on the in_
// channel while in_ready is high; a word with first_byte set starts a new
// attribute and samples its length. Each completed four-byte AS number, up
// to 1024 per path, leaves on the out_ channel with its index and the
// running total, and a malformed path gives one word with status set and
// path_done set, after which bytes are dropped until the next first byte.
// Words that complete nothing produce no output. The front stage parses
// bytes and posts events into a four-entry queue; the back stage numbers AS
// entries and holds the result in an output register. Throughput is one
// byte per cycle while in_ready is high, set by the single-byte parser.
// When the receiver stalls the output word holds, the queue fills and
// in_ready falls once it is full; nothing is lost.
// Reset (synchronous, rst_n low) empties the queue and output register and
// leaves the parser skipping until the first marked byte arrives.
module as_path_segment_flattener_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aspsf_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aspsf_pkg::out_word_t out_word
);

  logic              push, pop, q_not_full, q_not_empty;
  aspsf_pkg::event_t push_event, head;

  assign in_ready = q_not_full;

  aspsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && in_ready),
    .in_word    (in_word),
    .push       (push),
    .push_event (push_event)
  );

  aspsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_event (push_event),
    .not_full   (q_not_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  aspsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_not_empty),
    .ev        (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  import aspsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 520;

  // Tracks the parser state of the flattener and predicts every output word.
  class as_path_flattener_model;
    typedef enum logic [1:0] {
      SEG_TYPE  = 2'd0,
      SEG_COUNT = 2'd1,
      SEG_ASN   = 2'd2
    } seg_phase_t;

    out_word_t   pending_asns[$];
    int unsigned offset;
    int unsigned declared_len;
    seg_phase_t  phase;
    int unsigned asns_left;
    int unsigned byte_pos;
    int unsigned accum;
    int unsigned stored;
    bit          skipping;
    int          errors;
    int          bytes_parsed;
    int          asns_seen;
    int          bad_paths;

    function new();
      offset = 0;
      declared_len = 0;
      phase = SEG_TYPE;
      asns_left = 0;
      byte_pos = 0;
      accum = 0;
      stored = 0;
      skipping = 1'b1;
      errors = 0;
      bytes_parsed = 0;
      asns_seen = 0;
      bad_paths = 0;
    endfunction

    function void post(int unsigned asn, int unsigned idx, ev_kind_t st, bit done);
      out_word_t w;
      w.as_number = asn;
      w.as_index  = IDX_W'(idx);
      w.status    = st;
      w.path_done = done;
      w.as_total  = TOT_W'(stored);
      pending_asns.push_back(w);
      if (st == EV_BAD) begin
        bad_paths++;
      end else begin
        asns_seen++;
      end
    endfunction

    function void flag_malformed();
      skipping = 1'b1;
      post(0, 0, EV_BAD, 1'b1);
    endfunction

    function void absorb_byte(in_word_t w);
      int unsigned b;
      int unsigned len;
      int unsigned pos;
      int unsigned asn;
      bit          done;
      b   = w.path_byte;
      len = w.path_length;
      if (w.first_byte) begin
        offset = 0;
        phase = SEG_TYPE;
        asns_left = 0;
        byte_pos = 0;
        accum = 0;
        stored = 0;
        skipping = 1'b0;
        declared_len = len & 32'h1fff;
        bytes_parsed++;
        if (len < MIN_PATH_LEN || len > MAX_PATH_LEN || len[0]) begin
          flag_malformed();
          return;
        end
      end else if (skipping) begin
        return;
      end else begin
        bytes_parsed++;
      end
      pos = offset;
      offset = (offset + 1) & 32'h1fff;
      case (phase)
        SEG_COUNT: begin
          if (b == 0 || pos - 1 + HDR_BYTES + ASN_BYTES * b > declared_len) begin
            flag_malformed();
          end else begin
            asns_left = b;
            byte_pos = 0;
            accum = 0;
            phase = SEG_ASN;
          end
        end
        SEG_ASN: begin
          if (byte_pos < 3) begin
            accum = ((accum << 8) | b) & 32'hffffff;
            byte_pos++;
          end else begin
            asn = (accum << 8) | b;
            accum = 0;
            byte_pos = 0;
            asns_left = (asns_left - 1) & 32'hff;
            if (asns_left == 0) begin
              phase = SEG_TYPE;
            end
            done = (offset == declared_len);
            if (done) begin
              skipping = 1'b1;
            end
            if (stored < MAX_ASNS) begin
              stored++;
              post(asn, stored - 1, EV_ASN, done);
            end else if (done) begin
              post(0, 0, EV_ASN, 1'b1);
            end
          end
        end
        default: begin
          phase = SEG_COUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_asns.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_asns.pop_front();
      compare_field("as_number", want.as_number, got.as_number);
      compare_field("as_index", want.as_index, got.as_index);
      compare_field("status", want.status, got.status);
      compare_field("path_done", want.path_done, got.path_done);
      compare_field("as_total", want.as_total, got.as_total);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  bit                    idle_on = 1'b1;
  int                    quiet_cycles = 0;
  as_path_flattener_model flat_model = new();

  as_path_segment_flattener_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        flat_model.absorb_byte(in_word);
      end
      if (out_valid && out_ready) begin
        flat_model.check_word(out_word);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic put_word(input logic [7:0] b, input logic [15:0] len, input logic first);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{path_byte: b, path_length: len, first_byte: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input logic [15:0] len,
                            input int unsigned n);
    for (int i = 0; i < n && i < q.size(); i++) begin
      put_word(q[i], (i == 0) ? len : 16'($urandom), i == 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (flat_model.pending_asns.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] asn_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_count();
    if ($urandom_range(99) < 90) begin
      return $urandom_range(4, 1);
    end
    return $urandom_range(40, 5);
  endfunction

  function automatic void add_segment(ref logic [7:0] q[$], ref int unsigned cpos[$],
                                      input int unsigned count);
    q.push_back(8'($urandom));
    cpos.push_back(q.size());
    q.push_back(8'(count));
    repeat (4 * count) q.push_back(asn_byte());
  endfunction

  task automatic random_path();
    logic [7:0]  q[$];
    int unsigned cpos[$];
    int unsigned r;
    int unsigned k;
    int unsigned c;
    logic [15:0] len;
    r = $urandom_range(99);
    repeat ($urandom_range(3, 1)) add_segment(q, cpos, pick_count());
    if (r < 65) begin
      send_bytes(q, 16'(q.size()), q.size());
    end else if (r < 73) begin
      case ($urandom_range(3))
        0: len = 16'($urandom_range(5));
        1: len = 16'($urandom_range(MAX_PATH_LEN / 2 - 1, 3) * 2 + 1);
        2: len = 16'($urandom_range(65535, MAX_PATH_LEN + 1));
        default: len = 16'hffff;
      endcase
      send_bytes(q, len, $urandom_range(4, 1));
    end else if (r < 83) begin
      k = cpos[$urandom_range(cpos.size() - 1)];
      if ($urandom_range(1) == 1) begin
        q[k] = 8'h00;
      end else begin
        c = (q.size() - k - 1) / 4 + $urandom_range(3, 1);
        q[k] = (c > 255) ? 8'hff : 8'(c);
      end
      send_bytes(q, 16'(q.size()), k + 1 + $urandom_range(3));
    end else if (r < 91) begin
      send_bytes(q, 16'(q.size()), $urandom_range(q.size() - 1, 1));
    end else if (r < 96) begin
      if ($urandom_range(1) == 1) begin
        len = 16'(q.size() + 2 * $urandom_range(3, 1));
      end else begin
        len = 16'(q.size() - 2 * $urandom_range(2, 1));
      end
      send_bytes(q, len, q.size());
    end else begin
      repeat ($urandom_range(3, 1)) put_word(8'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  initial begin
    logic [7:0]  q[$];
    int unsigned cpos[$];
    int          target;
    int          leftover;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Shortest legal paths with the smallest and largest AS numbers.
    send_bytes('{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 16'd6, 6);
    send_bytes('{8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff}, 16'd6, 6);
    // Bad lengths: short, odd, too long, all ones and zero.
    put_word(8'h02, 16'd5, 1'b1);
    put_word(8'h02, 16'd7, 1'b1);
    put_word(8'h02, 16'd4098, 1'b1);
    put_word(8'h02, 16'hffff, 1'b1);
    put_word(8'h02, 16'd0, 1'b1);
    // A zero segment count, followed by a byte that must be ignored.
    send_bytes('{8'h02, 8'h00, 8'h55}, 16'd6, 3);
    // A segment count that runs past the declared length.
    send_bytes('{8'h02, 8'h03}, 16'd10, 2);
    settle();

    // A long path with the largest segment count, sent without gaps.
    idle_on = 1'b0;
    add_segment(q, cpos, 255);
    add_segment(q, cpos, 1);
    send_bytes(q, 16'(q.size()), q.size());
    // The longest legal length, cut short by a restart.
    send_bytes(q, 16'(MAX_PATH_LEN), 40);
    settle();
    idle_on = 1'b1;

    target = flat_model.bytes_parsed + RANDOM_BYTES;
    while (flat_model.bytes_parsed < target) begin
      random_path();
    end
    in_valid <= 1'b0;

    while (flat_model.pending_asns.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    leftover = flat_model.pending_asns.size();
    $display("Run parsed %0d attribute bytes, checking %0d AS number words", 
             flat_model.bytes_parsed, flat_model.asns_seen);
    $display("and %0d malformed-path words.", flat_model.bad_paths);
    if (flat_model.errors == 0 && leftover == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
